[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the string unescape rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside of reset
`define JSU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsu assertion failed");

// checked on every edge, reset included
`define JSU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("jsu assertion failed");

`endif

[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants for the json string unescape block
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int MAX_BURST       = 4;
    localparam int BURST_CNT_BITS  = 3;

    // result status codes
    localparam logic [2:0] ST_BYTE      = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_NO_QUOTE  = 3'd2;
    localparam logic [2:0] ST_BAD_HEX   = 3'd3;
    localparam logic [2:0] ST_BAD_SURR  = 3'd4;
    localparam logic [2:0] ST_BAD_ESC   = 3'd5;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd6;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX1    = 3'd2,
        MODE_WANT_BS = 3'd3,
        MODE_WANT_U  = 3'd4,
        MODE_HEX2    = 3'd5
    } mode_t;

    // one result as presented on the output side
    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic [2:0]  status;
        logic [15:0] length;
    } jsu_entry_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [BURST_CNT_BITS-1:0]       count;
        jsu_entry_t [MAX_BURST-1:0]      entry;
    } jsu_burst_t;

endpackage

[rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// jsu_decode
// escape state machine and utf-8 encoder, one input byte per accepted request
// ----------------------------------------------------------------------------
module jsu_decode #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [7:0]         in_byte,
    output jsu_pkg::jsu_burst_t burst
);
    import jsu_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam int                     SUM_BITS = LENGTH_BITS + 3;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             hex_count_reg, hex_count_next;
    logic [15:0]            hex_accum_reg, hex_accum_next;
    logic [9:0]             high_reg, high_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    logic [7:0]  eb [MAX_BURST];
    logic [2:0]  nb;
    logic        fin;
    logic [2:0]  fin_status;
    logic        do_enc;
    logic [20:0] cp;
    logic [4:0]  hex_d;
    logic [15:0] accum_new;
    logic        clear;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= "0" && c <= "9")      v = 5'(c - "0");
        else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
        return v;
    endfunction

    function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] len);
        logic [LENGTH_BITS+15:0] wide;
        wide = {16'b0, len};
        return wide[15:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] base,
        input logic [2:0]             inc
    );
        logic [SUM_BITS-1:0] sum;
        sum = {3'b0, base} + {{(SUM_BITS-3){1'b0}}, inc};
        if (sum > {3'b0, LEN_MAX}) return LEN_MAX;
        return sum[LENGTH_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            hex_count_reg <= '0;
            hex_accum_reg <= '0;
            high_reg      <= '0;
            count_reg     <= '0;
        end
        else if (in_fire)
        begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            hex_accum_reg <= hex_accum_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
        end
    end

    // escape handling: decides bytes, code point or ending status
    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        hex_accum_next = hex_accum_reg;
        high_next      = high_reg;
        fin            = 1'b0;
        fin_status     = ST_DONE;
        do_enc         = 1'b0;
        cp             = '0;
        clear          = 1'b0;
        nb             = 3'd0;
        for (int i = 0; i < MAX_BURST; i++)
        begin
            eb[i] = 8'h00;
        end
        hex_d     = hex_value(in_byte);
        accum_new = {hex_accum_reg[11:0], hex_d[3:0]};

        case (mode_reg)
            MODE_NORMAL:
            begin
                if (in_byte == "\"")
                begin
                    fin = 1'b1; fin_status = ST_DONE;
                end
                else if (in_byte == 8'h00)
                begin
                    fin = 1'b1; fin_status = ST_NO_QUOTE;
                end
                else if (in_byte == "\\")
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_byte < 8'h20)
                begin
                    fin = 1'b1; fin_status = ST_BAD_CHAR;
                end
                else
                begin
                    nb = 3'd1; eb[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_NORMAL;
                nb        = 3'd1;
                case (in_byte)
                    "\"":    eb[0] = 8'h22;
                    "\\":    eb[0] = 8'h5C;
                    "/":     eb[0] = 8'h2F;
                    "b":     eb[0] = 8'h08;
                    "f":     eb[0] = 8'h0C;
                    "n":     eb[0] = 8'h0A;
                    "r":     eb[0] = 8'h0D;
                    "t":     eb[0] = 8'h09;
                    "u":
                    begin
                        nb             = 3'd0;
                        mode_next      = MODE_HEX1;
                        hex_count_next = '0;
                        hex_accum_next = '0;
                    end
                    default:
                    begin
                        nb = 3'd0; fin = 1'b1; fin_status = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (hex_d[4])
                begin
                    fin = 1'b1; fin_status = ST_BAD_HEX;
                end
                else if (hex_count_reg != 2'd3)
                begin
                    hex_accum_next = accum_new;
                    hex_count_next = hex_count_reg + 2'd1;
                end
                else
                begin
                    hex_count_next = '0;
                    hex_accum_next = '0;
                    if (mode_reg == MODE_HEX1)
                    begin
                        if (accum_new >= HI_SURR_MIN && accum_new <= HI_SURR_MAX)
                        begin
                            high_next = accum_new[9:0];
                            mode_next = MODE_WANT_BS;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            do_enc    = 1'b1;
                            cp        = {5'b0, accum_new};
                        end
                    end
                    else if (accum_new >= LO_SURR_MIN && accum_new <= LO_SURR_MAX)
                    begin
                        high_next = '0;
                        mode_next = MODE_NORMAL;
                        do_enc    = 1'b1;
                        cp        = {1'b0, high_reg, accum_new[9:0]} + SUPP_BASE;
                    end
                    else
                    begin
                        fin = 1'b1; fin_status = ST_BAD_SURR;
                    end
                end
            end
            MODE_WANT_BS:
            begin
                if (in_byte == "\\") mode_next = MODE_WANT_U;
                else
                begin
                    fin = 1'b1; fin_status = ST_BAD_SURR;
                end
            end
            MODE_WANT_U:
            begin
                if (in_byte == "u")
                begin
                    mode_next      = MODE_HEX2;
                    hex_count_next = '0;
                    hex_accum_next = '0;
                end
                else
                begin
                    fin = 1'b1; fin_status = ST_BAD_SURR;
                end
            end
            default:
            begin
                clear = 1'b1;
            end
        endcase

        // utf-8 encoder
        if (do_enc)
        begin
            if (cp <= 21'h7F)
            begin
                nb = 3'd1; eb[0] = cp[7:0];
            end
            else if (cp <= 21'h7FF)
            begin
                nb    = 3'd2;
                eb[0] = {3'b110, cp[10:6]};
                eb[1] = {2'b10, cp[5:0]};
            end
            else if (cp <= 21'hFFFF)
            begin
                nb    = 3'd3;
                eb[0] = {4'b1110, cp[15:12]};
                eb[1] = {2'b10, cp[11:6]};
                eb[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                nb    = 3'd4;
                eb[0] = {5'b11110, cp[20:18]};
                eb[1] = {2'b10, cp[17:12]};
                eb[2] = {2'b10, cp[11:6]};
                eb[3] = {2'b10, cp[5:0]};
            end
        end

        if (fin || clear)
        begin
            mode_next      = MODE_NORMAL;
            hex_count_next = '0;
            hex_accum_next = '0;
            high_next      = '0;
        end
    end

    // result assembly with running length
    always_comb
    begin
        burst = '0;
        if (fin)
        begin
            burst.count           = 3'd1;
            burst.entry[0].status = fin_status;
            burst.entry[0].length = len16(count_reg);
            count_next            = '0;
        end
        else if (clear)
        begin
            count_next = '0;
        end
        else
        begin
            burst.count = nb;
            for (int i = 0; i < MAX_BURST; i++)
            begin
                burst.entry[i].data   = eb[i];
                burst.entry[i].valid  = (3'(i) < nb);
                burst.entry[i].status = ST_BYTE;
                burst.entry[i].length = len16(sat_add(count_reg, 3'(i + 1)));
            end
            count_next = sat_add(count_reg, nb);
        end
    end

endmodule

[rtl/jsu_burst.sv]
// ----------------------------------------------------------------------------
// jsu_burst
// result register holding the results of one input, drained one per cycle while out_ready is high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_burst (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jsu_pkg::jsu_burst_t burst,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output jsu_pkg::jsu_entry_t out_entry,
    output logic                out_last
);
    import jsu_pkg::*;

    jsu_entry_t [MAX_BURST-1:0] entry_reg;
    logic [BURST_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [1:0]                 rd_ptr_reg, rd_ptr_next;
    logic                       out_fire;

    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign free      = (cnt_reg == '0) || (cnt_reg == 3'd1 && out_ready);
    assign out_entry = entry_reg[rd_ptr_reg];
    assign out_last  = (cnt_reg == 3'd1);

    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        if (out_fire)
        begin
            cnt_next    = cnt_reg - 3'd1;
            rd_ptr_next = rd_ptr_reg + 2'd1;
        end
        if (load)
        begin
            cnt_next    = burst.count;
            rd_ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= burst.entry;
        end
    end

    `JSU_ASSERT_ALWAYS(a_cnt_range, !rst_n || cnt_reg <= 3'd4)
    `JSU_ASSERT(a_load_when_free, load |-> (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_fire)))
    `JSU_ASSERT(a_ptr_step, (out_fire && cnt_reg > 3'd1 && !load) |=> rd_ptr_reg == $past(rd_ptr_reg) + 2'd1)
    `JSU_ASSERT(a_status_is_last, (out_valid && !out_entry.valid) |-> out_last)

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// latency: first result of an input byte shows on the cycle after its request
// throughput: one input byte per cycle while the output is ready; a byte
//   yielding more than one result (up to four for a surrogate pair) holds
//   the input while the result register drains one result per ready cycle
// reset: rst_n async active low, returns to the string body with zero length
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream of raw string body bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // output stream of decoded bytes and status
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] string_length
    output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic        m_axis_tlast    // last result of this input byte
);
    import jsu_pkg::*;

    jsu_burst_t burst;
    jsu_entry_t out_entry;
    logic       in_fire;
    logic       free;

    // a request is taken whenever the result register is empty or drains now
    assign s_axis_tready = free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // decoder: escape state, hex accumulation, utf-8 encoding, length count
    jsu_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (s_axis_tdata),
        .burst   (burst)
    );

    // result register: the whole burst lands here and leaves one per cycle while m_axis_tready is high
    jsu_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .burst     (burst),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry),
        .out_last  (m_axis_tlast)
    );

    // output packing, lowest field first
    assign m_axis_tdata = {out_entry.length, out_entry.data};
    assign m_axis_tuser = {out_entry.status, out_entry.valid};

endmodule

[verif/json_string_unescape_utf8_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker
// watches both streams, decodes every accepted request on its own copy of the
// decoder state and compares each result with the oldest decoded one
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;

    typedef struct {
        logic [7:0]  data;
        logic        valid;
        logic [2:0]  status;
        logic [15:0] length;
        logic        last;
    } decoded_t;

    mode_t                  dec_mode;
    logic [1:0]             hex_cnt;
    logic [15:0]            hex_acc;
    logic [9:0]             hi_surr;
    logic [LENGTH_BITS-1:0] byte_count;
    decoded_t               decoded_q[$];
    int                     step_results;

    task automatic clear_decoder();
        dec_mode   = MODE_NORMAL;
        hex_cnt    = '0;
        hex_acc    = '0;
        hi_surr    = '0;
        byte_count = '0;
    endtask

    task automatic push_result(input logic [7:0] data, input logic valid,
                               input logic [2:0] status);
        decoded_t e;
        e.data   = data;
        e.valid  = valid;
        e.status = status;
        e.length = 16'(byte_count);
        e.last   = 1'b0;
        decoded_q.push_back(e);
        step_results++;
    endtask

    // counter saturates at all ones
    task automatic emit_byte(input logic [7:0] b);
        if (!(&byte_count))
            byte_count++;
        push_result(b, 1'b1, ST_BYTE);
    endtask

    // done and every error report the length, then drop all state
    task automatic emit_status(input logic [2:0] status);
        push_result(8'h00, 1'b0, status);
        clear_decoder();
    endtask

    task automatic emit_code_point(input logic [20:0] u);
        if (u <= 21'h7F) begin
            emit_byte(u[7:0]);
        end
        else if (u <= 21'h7FF) begin
            emit_byte({3'b110, u[10:6]});
            emit_byte({2'b10, u[5:0]});
        end
        else if (u <= 21'hFFFF) begin
            emit_byte({4'b1110, u[15:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end
        else begin
            emit_byte({5'b11110, u[20:18]});
            emit_byte({2'b10, u[17:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end
    endtask

    // 16 marks a byte that is not a hex digit
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 10);
        return 5'd16;
    endfunction

    task automatic decode_request(input logic [7:0] c);
        logic [4:0]  d;
        logic [20:0] u;
        step_results = 0;
        case (dec_mode)
            MODE_NORMAL:
            begin
                if (c == CH_QUOTE)
                    emit_status(ST_DONE);
                else if (c == 8'h00)
                    emit_status(ST_NO_QUOTE);
                else if (c == CH_BACKSLASH)
                    dec_mode = MODE_ESC;
                else if (c < 8'h20)
                    emit_status(ST_BAD_CHAR);
                else
                    emit_byte(c);
            end
            MODE_ESC:
            begin
                dec_mode = MODE_NORMAL;
                case (c)
                    CH_QUOTE:     emit_byte(8'h22);
                    CH_BACKSLASH: emit_byte(8'h5C);
                    CH_SLASH:     emit_byte(8'h2F);
                    "b":          emit_byte(8'h08);
                    "f":          emit_byte(8'h0C);
                    "n":          emit_byte(8'h0A);
                    "r":          emit_byte(8'h0D);
                    "t":          emit_byte(8'h09);
                    "u":
                    begin
                        dec_mode = MODE_HEX1;
                        hex_cnt  = '0;
                        hex_acc  = '0;
                    end
                    default:      emit_status(ST_BAD_ESC);
                endcase
            end
            MODE_HEX1, MODE_HEX2:
            begin
                d = hex_digit_value(c);
                if (d[4]) begin
                    emit_status(ST_BAD_HEX);
                end
                else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt++;
                    end
                    else begin
                        hex_cnt = '0;
                        if (dec_mode == MODE_HEX1) begin
                            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                hi_surr  = hex_acc[9:0];
                                dec_mode = MODE_WANT_BS;
                            end
                            else begin
                                dec_mode = MODE_NORMAL;
                                emit_code_point(21'(hex_acc));
                            end
                            hex_acc = '0;
                        end
                        else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                            // join the pair into one code point above the bmp
                            u = 21'h10000 + {1'b0, hi_surr, 10'h000} + 21'(hex_acc[9:0]);
                            hi_surr  = '0;
                            hex_acc  = '0;
                            dec_mode = MODE_NORMAL;
                            emit_code_point(u);
                        end
                        else begin
                            emit_status(ST_BAD_SURR);
                        end
                    end
                end
            end
            MODE_WANT_BS:
            begin
                if (c == CH_BACKSLASH)
                    dec_mode = MODE_WANT_U;
                else
                    emit_status(ST_BAD_SURR);
            end
            MODE_WANT_U:
            begin
                if (c == "u") begin
                    dec_mode = MODE_HEX2;
                    hex_cnt  = '0;
                    hex_acc  = '0;
                end
                else begin
                    emit_status(ST_BAD_SURR);
                end
            end
            default: clear_decoder();
        endcase
        if (step_results > 0)
            decoded_q[decoded_q.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        decoded_t e;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: out_byte %0h status %0d", m_axis_tdata[7:0],
                   m_axis_tuser[3:1]);
            fail_count++;
        end
        else begin
            e = decoded_q.pop_front();
            if (m_axis_tdata[7:0] !== e.data) begin
                $error("out_byte: expected %0h, actual %0h", e.data, m_axis_tdata[7:0]);
                fail_count++;
            end
            if (m_axis_tuser[0] !== e.valid) begin
                $error("byte_valid: expected %0d, actual %0d", e.valid, m_axis_tuser[0]);
                fail_count++;
            end
            if (m_axis_tuser[3:1] !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, m_axis_tuser[3:1]);
                fail_count++;
            end
            if (m_axis_tdata[23:8] !== e.length) begin
                $error("string_length: expected %0d, actual %0d", e.length,
                       m_axis_tdata[23:8]);
                fail_count++;
            end
            if (m_axis_tlast !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, m_axis_tlast);
                fail_count++;
            end
        end
    endtask

    // results first: a request never yields a result on its own edge
    always @(posedge clk)
    begin
        if (!rst_n) begin
            clear_decoder();
            decoded_q.delete();
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                decode_request(s_axis_tdata);
        end
        pending = decoded_q.size();
    end

endmodule

[verif/tb_json_string_unescape_utf8_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// drives json string bodies into the unescape block with random gaps and
// output stalls; a short directed set first, then random well-formed strings
// ended by a quote or by one of the error paths, plus one long string sent
// with no idling on either side
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;

    // full 16-bit length counter
    localparam int LEN_BITS     = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 28;
    localparam int ITEM_TARGET  = 170;
    localparam int LONG_TOKENS  = 40;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [7:0] out_byte, [23:8] string_length
    logic [3:0]  m_axis_tuser;    // [0] byte_valid, [3:1] status
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          cycles;
    int          items_sent;
    // when set neither side idles
    logic        calm;
    // set once the long string has gone out
    logic        long_done;
    // body bytes of the string being built
    logic [7:0]  body_q[$];

    json_string_unescape_utf8_top #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    json_string_unescape_utf8_checker #(
        .LENGTH_BITS (LEN_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stalls at random outside the calm stretch
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one request; random gap first, then hold until accepted
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_body();
        foreach (body_q[i])
            send_byte(body_q[i]);
        body_q.delete();
    endtask

    // always waits for a falling edge before returning so tvalid is never lowered and
    // raised in the same step
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // mixes upper and lower case letters
    task automatic push_hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            body_q.push_back(8'("0") + 8'(nib));
        else if ($urandom_range(1, 0))
            body_q.push_back(8'("a") + 8'(nib) - 8'd10);
        else
            body_q.push_back(8'("A") + 8'(nib) - 8'd10);
    endtask

    task automatic push_u_escape(input logic [15:0] v);
        body_q.push_back(CH_BACKSLASH);
        body_q.push_back("u");
        for (int i = 3; i >= 0; i--)
            push_hex_digit(v[i*4 +: 4]);
    endtask

    // an escape cut short after a few good digits
    task automatic push_partial_u(input int digits);
        body_q.push_back(CH_BACKSLASH);
        body_q.push_back("u");
        repeat (digits)
            push_hex_digit(4'($urandom_range(15, 0)));
    endtask

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        if ($urandom_range(3, 0) == 0)
            return 8'h00;
        do
            c = 8'($urandom_range(255, 0));
        while (is_hex_char(c));
        return c;
    endfunction

    function automatic logic [7:0] random_plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h7F, 8'h20));
        while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    // bmp value outside the high surrogate range, encodes to three bytes
    function automatic logic [15:0] random_three_byte();
        if ($urandom_range(1, 0))
            return 16'($urandom_range(16'hD7FF, 16'h0800));
        return 16'($urandom_range(16'hFFFF, 16'hDC00));
    endfunction

    task automatic push_surrogate_pair();
        push_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
        push_u_escape(16'($urandom_range(16'hDFFF, 16'hDC00)));
    endtask

    task automatic push_random_token();
        int         pick;
        logic [7:0] simple_esc[8];
        simple_esc = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, "b", "f", "n", "r", "t"};
        pick = $urandom_range(99, 0);
        if (pick < 32) begin
            body_q.push_back(random_plain_char());
        end
        else if (pick < 46) begin
            body_q.push_back(8'($urandom_range(8'hFF, 8'h80)));
        end
        else if (pick < 62) begin
            body_q.push_back(CH_BACKSLASH);
            body_q.push_back(simple_esc[$urandom_range(7, 0)]);
        end
        else if (pick < 68) begin
            push_u_escape(16'($urandom_range(16'h007F, 16'h0000)));
        end
        else if (pick < 74) begin
            push_u_escape(16'($urandom_range(16'h07FF, 16'h0080)));
        end
        else if (pick < 82) begin
            push_u_escape(random_three_byte());
        end
        else if (pick < 94) begin
            push_surrogate_pair();
        end
        else begin
            // lone low surrogate
            push_u_escape(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
    endtask

    // ends a string on one of the error paths
    task automatic push_error_tail();
        logic [7:0]  c;
        logic [15:0] v;
        case ($urandom_range(7, 0))
            0: body_q.push_back(8'h00);
            1: body_q.push_back(8'($urandom_range(8'h1F, 8'h01)));
            2:
            begin
                // unknown escape letter, nul included
                if ($urandom_range(3, 0) == 0) begin
                    c = 8'h00;
                end
                else begin
                    do
                        c = 8'($urandom_range(255, 0));
                    while (c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, "b", "f", "n", "r",
                                     "t", "u"});
                end
                body_q.push_back(CH_BACKSLASH);
                body_q.push_back(c);
            end
            3:
            begin
                push_partial_u($urandom_range(3, 0));
                body_q.push_back(random_non_hex());
            end
            4:
            begin
                // high surrogate with no second escape
                push_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
                do
                    c = 8'($urandom_range(255, 0));
                while (c == CH_BACKSLASH);
                body_q.push_back(c);
            end
            5:
            begin
                push_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
                body_q.push_back(CH_BACKSLASH);
                do
                    c = 8'($urandom_range(255, 0));
                while (c == "u");
                body_q.push_back(c);
            end
            6:
            begin
                // second escape outside the low surrogate range
                push_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
                do
                    v = 16'($urandom_range(16'hFFFF, 0));
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                push_u_escape(v);
            end
            default:
            begin
                push_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
                push_partial_u($urandom_range(3, 0));
                body_q.push_back(random_non_hex());
            end
        endcase
    endtask

    initial
    begin
        rst_n         = 1'b0;
        calm          = 1'b0;
        long_done     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        items_sent    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: plain byte extremes and 0x7f raw, a control escape, done;
        // 0x7f as an escape, the largest code point from mixed-case digits,
        // done; then a nul and a raw control byte as their own strings
        body_q = '{8'h20, 8'hFF, 8'h80, 8'h7F, CH_BACKSLASH, "t", CH_QUOTE,
                   CH_BACKSLASH, "u", "0", "0", "7", "F",
                   CH_BACKSLASH, "u", "D", "B", "F", "F",
                   CH_BACKSLASH, "u", "d", "F", "f", "F", CH_QUOTE,
                   8'h00, 8'h1F};
        send_body();

        // hold off until every result is back
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 60 && !long_done && body_q.size() == 0) begin
                // long string with no idling on either side
                calm      = 1'b1;
                long_done = 1'b1;
                repeat (LONG_TOKENS) begin
                    if ($urandom_range(3, 0) == 0)
                        body_q.push_back(8'($urandom_range(8'hFF, 8'h80)));
                    else
                        body_q.push_back(random_plain_char());
                end
                push_surrogate_pair();
                push_u_escape(16'h007F);
                body_q.push_back(CH_QUOTE);
                send_body();
                calm = 1'b0;
            end
            else begin
                repeat ($urandom_range(12, 0))
                    push_random_token();
                if ($urandom_range(99, 0) < 78)
                    body_q.push_back(CH_QUOTE);
                else
                    push_error_tail();
                send_body();
            end
        end

        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_burst.sv
rtl/json_string_unescape_utf8_top.sv
verif/json_string_unescape_utf8_checker.sv
verif/tb_json_string_unescape_utf8_top.sv
